[src/sida_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal text: shared package
// Types and constants used by the front end, the job queue and the emitter.
// ----------------------------------------------------------------------------
package sida_pkg;

    // Input and output widths.
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    // Index of a decimal position, 0 .. 9.
    localparam int POS_W   = 4;
    // Wide enough for 9 * 10^9 without overflow.
    localparam int MULT_W  = 34;
    localparam int MAX_POS = 9;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // One classified number waiting for the emitter.
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [POS_W-1:0]   top_pos;
    } t_job;

    // Power of ten for a decimal position.
    function automatic logic [MULT_W-1:0] pow10(input logic [POS_W-1:0] pos);
        logic [MULT_W-1:0] p;
        begin
            case (pos)
                4'd0:    p = 34'd1;
                4'd1:    p = 34'd10;
                4'd2:    p = 34'd100;
                4'd3:    p = 34'd1000;
                4'd4:    p = 34'd10000;
                4'd5:    p = 34'd100000;
                4'd6:    p = 34'd1000000;
                4'd7:    p = 34'd10000000;
                4'd8:    p = 34'd100000000;
                4'd9:    p = 34'd1000000000;
                default: p = 34'd1;
            endcase
            return p;
        end
    endfunction

endpackage

[src/sida_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal text: front end
// Accepts a value, splits it into sign and magnitude, finds the position of
// its leading decimal digit and registers the resulting job.
// ----------------------------------------------------------------------------
module sida_front
    import sida_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_job_valid,
    input  logic                      i_job_ready,
    output t_job                      o_job
);

    logic               r_valid;
    logic               n_valid;
    t_job               r_job;
    logic               w_take;
    logic               w_neg;
    logic [VALUE_W-1:0] w_mag;
    logic [POS_W-1:0]   w_top;

    // The stage can take a new request when empty or when it is drained.
    assign o_ready = !r_valid || i_job_ready;
    assign w_take  = i_valid && o_ready;

    // Sign and magnitude; the most negative value wraps to 2^31 unsigned.
    always_comb begin
        w_neg = i_value[VALUE_W-1];
        w_mag = w_neg ? (VALUE_W'(0) - VALUE_W'(i_value)) : VALUE_W'(i_value);
    end

    // Leading digit position: how many powers of ten the magnitude reaches.
    always_comb begin
        w_top = '0;
        for (int k = 1; k <= MAX_POS; k++) begin
            if ({2'b00, w_mag} >= pow10(POS_W'(k))) begin
                w_top = w_top + POS_W'(1);
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_job_ready) begin
            n_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Job payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job.neg     <= w_neg;
            r_job.mag     <= w_mag;
            r_job.top_pos <= w_top;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;

endmodule

[src/sida_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal text: job queue
// Two-entry queue that decouples the front end from the emitter.
// ----------------------------------------------------------------------------
module sida_fifo
    import sida_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;
    logic [1:0] n_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Pointer and fill count update.
    always_comb begin
        n_wr  = w_push ? !r_wr : r_wr;
        n_rd  = w_pop ? !r_rd : r_rd;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

[src/sida_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal text: character emitter
// Takes jobs from the queue and emits the sign and one decimal digit per cycle
// unless stalled, most significant first, into a registered output stage.
// ----------------------------------------------------------------------------
module sida_back
    import sida_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  t_job              i_job,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last
);

    logic               r_busy;
    logic               r_neg;
    logic [VALUE_W-1:0] r_rem;
    logic [POS_W-1:0]   r_pos;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    logic               n_busy;
    logic               n_neg;
    logic [VALUE_W-1:0] n_rem;
    logic [POS_W-1:0]   n_pos;
    logic               n_out_valid;
    logic [CHAR_W-1:0]  n_char;
    logic               n_last;

    logic               w_step;
    logic               w_done;
    logic               w_load;
    logic [MULT_W-1:0]  w_pow;
    logic [MULT_W-1:0]  w_mult [10];
    logic [DIGIT_W-1:0] w_digit;
    logic [MULT_W-1:0]  w_sub;

    // One character is produced whenever the output register can take it.
    assign w_step      = r_busy && (!r_out_valid || i_ready);
    assign w_done      = w_step && !r_neg && (r_pos == '0);
    assign w_load      = i_job_valid && (!r_busy || w_done);
    assign o_job_ready = w_load;

    // Digit at the current position: the largest multiple of 10^pos that fits.
    always_comb begin
        w_pow   = pow10(r_pos);
        w_digit = '0;
        w_sub   = '0;
        for (int d = 0; d < 10; d++) begin
            w_mult[d] = w_pow * MULT_W'(d);
        end
        for (int d = 1; d < 10; d++) begin
            if ({2'b00, r_rem} >= w_mult[d]) begin
                w_digit = DIGIT_W'(d);
                w_sub   = w_mult[d];
            end
        end
    end

    // Sequencer and output stage next values.
    always_comb begin
        n_busy      = r_busy;
        n_neg       = r_neg;
        n_rem       = r_rem;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;

        if (w_step) begin
            n_out_valid = 1'b1;
            if (r_neg) begin
                n_char = ASCII_MINUS;
                n_last = 1'b0;
                n_neg  = 1'b0;
            end else begin
                n_char = ASCII_ZERO + CHAR_W'(w_digit);
                n_last = (r_pos == '0);
                n_rem  = r_rem - w_sub[VALUE_W-1:0];
                if (r_pos == '0) begin
                    n_busy = 1'b0;
                end else begin
                    n_pos = r_pos - POS_W'(1);
                end
            end
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end

        // A new job may start in the cycle that the previous one finishes.
        if (w_load) begin
            n_busy = 1'b1;
            n_neg  = i_job.neg;
            n_rem  = i_job.mag;
            n_pos  = i_job.top_pos;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers and output payload.
    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_rem  <= n_rem;
        r_pos  <= n_pos;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

[src/signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII text
// Converts each signed 32-bit value into its decimal characters.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one request per value: a signed 32-bit integer
//   in tdata. The master channel returns its text one character per
//   transfer, most significant first: an optional '-', then the digits with
//   no leading zeros ("0" for zero, "-2147483648" for the most negative
//   value). tlast marks the final character of each number.
//   Each request passes through the front-end register, the job queue and
//   the emitter before its first character reaches the output register.
//   Each number occupies the emitter while its 1 to 11 characters are sent;
//   the emitter produces exactly one character per cycle while the receiver
//   is ready and starts the next number without a gap. The front end and a
//   two-entry job queue keep accepting requests while the emitter works.
//   Reset (synchronous, active low) empties the queue and drops any partial
//   text. When the receiver stalls, the current character holds in the
//   output register and the emitter, then the queue, then the input stall.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
    import sida_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic signed [VALUE_W-1:0] i_s_axis_tdata,  // [31:0] value
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [CHAR_W-1:0]         o_m_axis_tdata,  // [7:0] character
    output logic                      o_m_axis_tlast
);

    logic w_front_valid;
    logic w_front_ready;
    t_job w_front_job;
    logic w_queue_valid;
    logic w_queue_ready;
    t_job w_queue_job;

    // Sign, magnitude and digit count.
    sida_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_value     (i_s_axis_tdata),
        .o_job_valid (w_front_valid),
        .i_job_ready (w_front_ready),
        .o_job       (w_front_job)
    );

    // Job queue between the two halves.
    sida_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .i_job   (w_front_job),
        .o_valid (w_queue_valid),
        .i_ready (w_queue_ready),
        .o_job   (w_queue_job)
    );

    // Character emitter.
    sida_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_queue_valid),
        .o_job_ready (w_queue_ready),
        .i_job       (w_queue_job),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_char      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the signed integer to decimal ASCII converter
// Sends signed 32-bit values on the slave channel and checks every returned
// character and its tlast flag against text worked out locally. Runs a short
// directed set of edge values, then random values spread over all digit
// counts and both signs, under three mixes of sender and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import sida_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_LEN   = 12;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 600000;

    // One expected output character.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      s_valid  = 1'b0;
    logic signed [VALUE_W-1:0] s_data   = '0;
    logic                      m_ready  = 1'b0;
    logic                      s_ready;
    logic                      m_valid;
    logic [CHAR_W-1:0]         m_data;
    logic                      m_last;

    t_text_char  text_expected[$];
    int          err_count    = 0;
    int          cycle_count  = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    signed_int_to_decimal_ascii i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [31:0] value
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [7:0] character
        .o_m_axis_tlast  (m_last)
    );

    // Free-running clock.
    always #CLK_HALF clk = ~clk;

    // Receiver stalls at random according to the current idle percentage.
    always @(negedge clk) begin
        m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Appends the decimal text of one value to the expected characters.
    function automatic void expect_decimal_text(input logic [VALUE_W-1:0] value);
        logic             neg;
        logic [VALUE_W-1:0] mag;
        logic [3:0]       digits [10];
        int               nd;
        t_text_char       c;
        neg = value[VALUE_W-1];
        // Two's complement negation also covers the most negative value.
        mag = neg ? (~value + 1'b1) : value;
        nd  = 0;
        do begin
            digits[nd] = 4'(mag % 10);
            nd++;
            mag = mag / 10;
        end while (mag != 0);
        if (neg) begin
            c.code = ASCII_MINUS;
            c.last = 1'b0;
            text_expected.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            c.code = ASCII_ZERO + CHAR_W'(digits[k]);
            c.last = (k == 0);
            text_expected.push_back(c);
        end
    endfunction

    // Sends one value, with random idle cycles ahead of it, and records its
    // text once the request is accepted.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= value;
        do @(posedge clk); while (!s_ready);
        expect_decimal_text(value);
    endtask

    // Drops the request line and waits until every character has come back.
    task automatic wait_text_drained();
        @(negedge clk);
        s_valid <= 1'b0;
        while (text_expected.size() != 0) @(posedge clk);
    endtask

    // Random value: mostly a uniform digit count with a random sign.
    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned ndig;
        int unsigned p;
        int unsigned lo;
        int unsigned hi;
        logic [VALUE_W-1:0] mag;
        if ($urandom_range(9, 0) == 0) return $urandom();
        ndig = $urandom_range(10, 1);
        p = 1;
        repeat (ndig - 1) p = p * 10;
        lo  = (ndig == 1) ? 0 : p;
        hi  = (ndig == 10) ? 32'h7FFF_FFFF : p * 10 - 1;
        mag = $urandom_range(hi, lo);
        return $urandom_range(1, 0) ? (~mag + 1'b1) : mag;
    endfunction

    // Edge values: zero, single digits, several digit-count boundaries, both
    // extremes including the most negative value, and alternating bit masks.
    task automatic test_directed_values();
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(32'd99);
        send_value(32'd100);
        send_value(-32'sd9999);
        send_value(32'd123456789);
        send_value(-32'sd123456789);
        send_value(32'd999999999);
        send_value(-32'sd999999999);
        send_value(32'd1000000000);
        send_value(-32'sd1000000000);
        send_value(32'd1000000001);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h8000_0001);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);
        send_value(32'd1234567890);
    endtask

    task automatic test_random_values(input int count);
        repeat (count) send_value(random_value());
    endtask

    // Compares every accepted character with the oldest expectation.
    always @(posedge clk) begin : check_output
        t_text_char want;
        if (rst_n && m_valid && m_ready) begin
            if (text_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                          m_data, m_last));
            end else begin
                want = text_expected.pop_front();
                if (m_data !== want.code)
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              m_data, want.code));
                if (m_last !== want.last)
                    report_mismatch($sformatf("tlast %0b on 0x%02h, expected %0b",
                                              m_last, m_data, want.last));
            end
        end
    end

    initial begin
        repeat (RESET_LEN) @(negedge clk);
        rst_n <= 1'b1;

        // Sender mostly busy, receiver mostly stalled.
        send_idle_pct = 17;
        recv_idle_pct = 80;
        test_directed_values();
        test_random_values(60);
        wait_text_drained();

        // Sender mostly idle, receiver mostly ready.
        send_idle_pct = 80;
        recv_idle_pct = 17;
        test_random_values(50);
        wait_text_drained();

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_directed_values();
        test_random_values(46);
        wait_text_drained();

        // Catch any stray character after the last expected one.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (text_expected.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived",
                                      text_expected.size()));
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
src/sida_pkg.sv
src/sida_front.sv
src/sida_fifo.sv
src/sida_back.sv
src/signed_int_to_decimal_ascii.sv
tb/testbench.sv
